>>> rtl/fixed_decimal_to_seven_segment_4digit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment display encoder
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_DECIMAL_TO_SEVEN_SEGMENT_4DIGIT_ASSERT_SVH
`define FIXED_DECIMAL_TO_SEVEN_SEGMENT_4DIGIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, ignored while reset is high.
`define FDSS_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, also checked across reset.
`define FDSS_ASSERT_NEXT(lbl, clk_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FDSS_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons)
`define FDSS_ASSERT_NEXT(lbl, clk_sig, ante, cons)
`endif

`endif

>>> rtl/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and helper functions of the display encoder.
// ----------------------------------------------------------------------------
package fdss_pkg;

  // Configuration register indexes.
  localparam logic REG_DECIMALS = 1'b0;
  localparam logic REG_INVERT   = 1'b1;

  // Decimals mode code that selects one decimal place; all others mean two.
  localparam logic [1:0] MODE_ONE_DECIMAL = 2'd1;
  localparam logic [1:0] MODE_RESET       = 2'd2;

  // Segment patterns.
  localparam logic [7:0] DASH_PATTERN  = 8'h40;
  localparam logic [7:0] ZERO_PATTERN  = 8'h3F;
  localparam logic [7:0] POINT_BIT     = 8'h80;
  localparam logic [7:0] BLANK_PATTERN = 8'h00;

  // Range thresholds in hundredths.
  localparam logic [23:0] LIMIT_HUNDREDTHS = 24'd1000000;
  localparam logic [19:0] LIMIT_TENTHS     = 20'd100000;
  localparam logic [19:0] LIMIT_UNITS      = 20'd10000;

  // Reciprocal constants: x/10 = (x*MUL_DIV10)>>23, x/100 = (x*MUL_DIV100)>>26,
  // exact for x below one million; n/100 = (n*MUL_HI)>>19 for n below 10000.
  localparam logic [19:0] MUL_DIV10  = 20'd838861;
  localparam logic [19:0] MUL_DIV100 = 20'd671089;
  localparam logic [12:0] MUL_HI     = 13'd5243;

  typedef enum logic [1:0] {
    SCALE_1   = 2'd0,
    SCALE_10  = 2'd1,
    SCALE_100 = 2'd2
  } scale_t;

  // Control bits that follow an item through the back end.
  typedef struct packed {
    logic   err;
    logic   zero;
    logic   one_dec;
    logic   point1;
    logic   point2;
    scale_t scale;
  } ctl_t;

  // Classified item held in the queue.
  typedef struct packed {
    ctl_t        ctl;
    logic [19:0] value;
  } cls_t;

  // Standard gfedcba font for one decimal digit.
  function automatic logic [7:0] font(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Tens digit of a value below 100, found by independent threshold compares.
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

endpackage

>>> rtl/fdss_front.sv
// ----------------------------------------------------------------------------
// fdss_front
// Classifies an incoming value: range check, scale and point position.
// ----------------------------------------------------------------------------
module fdss_front
  import fdss_pkg::*;
(
  input  logic [23:0] value,
  input  logic [1:0]  decimals_mode,
  output cls_t        cls
);

  logic        neg;
  logic        too_big;
  logic [19:0] raw;

  assign neg     = value[23];
  assign too_big = value >= LIMIT_HUNDREDTHS;
  assign raw     = value[19:0];

  // Pick the scale and the point position from the magnitude and the mode.
  always_comb begin
    cls.value       = raw;
    cls.ctl.err     = neg | too_big;
    cls.ctl.one_dec = (decimals_mode == MODE_ONE_DECIMAL);
    cls.ctl.zero    = 1'b0;
    cls.ctl.point1  = 1'b0;
    cls.ctl.point2  = 1'b0;
    cls.ctl.scale   = SCALE_100;
    if (cls.ctl.one_dec) begin
      if (raw < LIMIT_TENTHS) begin
        cls.ctl.scale  = SCALE_10;
        cls.ctl.point2 = 1'b1;
      end
    end else begin
      cls.ctl.zero = (raw == 20'd0);
      if (raw < LIMIT_UNITS) begin
        cls.ctl.scale  = SCALE_1;
        cls.ctl.point1 = 1'b1;
      end else if (raw < LIMIT_TENTHS) begin
        cls.ctl.scale  = SCALE_10;
        cls.ctl.point2 = 1'b1;
      end
    end
  end

endmodule

>>> rtl/fdss_queue.sv
// ----------------------------------------------------------------------------
// fdss_queue
// Two-entry queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module fdss_queue
  import fdss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_cls,
  input  logic pop,
  output logic full,
  output logic out_valid,
  output cls_t out_cls
);

  cls_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cls   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cls;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/fdss_back.sv
// ----------------------------------------------------------------------------
// fdss_back
// Scales a classified item, splits it into digits and drives the patterns.
// ----------------------------------------------------------------------------
module fdss_back
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  cls_t        in_cls,
  output logic        pop,
  input  logic        invert_segments,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);

  logic        advance;

  logic        s1_valid;
  ctl_t        s1_ctl;
  logic [39:0] s1_prod;
  logic [13:0] s1_low;

  logic        s2_valid;
  ctl_t        s2_ctl;
  logic [13:0] s2_n;
  logic [6:0]  s2_hi;

  logic        s3_valid;
  ctl_t        s3_ctl;
  logic [6:0]  s3_hi;
  logic [6:0]  s3_lo;

  logic [19:0] mult;
  logic [13:0] n;
  logic [26:0] hi_prod;
  logic [13:0] lo_full;
  logic [3:0]  dig0;
  logic [3:0]  dig1;
  logic [3:0]  dig2;
  logic [3:0]  dig3;
  logic [7:0]  pat0;
  logic [7:0]  pat1;
  logic [7:0]  pat2;
  logic [7:0]  pat3;

  // The whole pipeline moves when the output register is free or drained.
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && in_valid;

  // Stage 1: multiply by the reciprocal of 10 or 100.
  assign mult = (in_cls.ctl.scale == SCALE_100) ? MUL_DIV100 : MUL_DIV10;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl  <= in_cls.ctl;
      s1_prod <= 40'(in_cls.value) * 40'(mult);
      s1_low  <= in_cls.value[13:0];
    end
  end

  // Stage 2: pick the scaled value and take its hundreds part.
  always_comb begin
    case (s1_ctl.scale)
      SCALE_1:  n = s1_low;
      SCALE_10: n = s1_prod[36:23];
      default:  n = s1_prod[39:26];
    endcase
  end

  assign hi_prod = 27'(n) * 27'(MUL_HI);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl <= s1_ctl;
      s2_n   <= n;
      s2_hi  <= hi_prod[25:19];
    end
  end

  // Stage 3: remainder below one hundred, by shift-and-add of the quotient.
  assign lo_full = s2_n - ((14'(s2_hi) << 6) + (14'(s2_hi) << 5) + (14'(s2_hi) << 2));

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ctl <= s2_ctl;
      s3_hi  <= s2_hi;
      s3_lo  <= lo_full[6:0];
    end
  end

  // Output stage: digits, font, point, blanking and inversion.
  assign dig0 = tens_of(s3_hi);
  assign dig1 = 4'(s3_hi - ((7'(dig0) << 3) + (7'(dig0) << 1)));
  assign dig2 = tens_of(s3_lo);
  assign dig3 = 4'(s3_lo - ((7'(dig2) << 3) + (7'(dig2) << 1)));

  always_comb begin
    pat0 = font(dig0);
    pat1 = font(dig1);
    pat2 = font(dig2);
    pat3 = font(dig3);
    if (s3_ctl.point1) begin
      pat1 = pat1 | POINT_BIT;
    end
    if (s3_ctl.point2) begin
      pat2 = pat2 | POINT_BIT;
    end
    // Leading zero blanking; the second digit only in one-decimal mode.
    if (dig0 == 4'd0) begin
      pat0 = BLANK_PATTERN;
      if (s3_ctl.one_dec && dig1 == 4'd0) begin
        pat1 = BLANK_PATTERN;
      end
    end
    if (s3_ctl.zero) begin
      pat0 = BLANK_PATTERN;
      pat1 = BLANK_PATTERN;
      pat2 = BLANK_PATTERN;
      pat3 = ZERO_PATTERN;
    end
    if (s3_ctl.err) begin
      pat0 = DASH_PATTERN;
      pat1 = DASH_PATTERN;
      pat2 = DASH_PATTERN;
      pat3 = DASH_PATTERN;
    end
    if (invert_segments) begin
      pat0 = ~pat0;
      pat1 = ~pat1;
      pat2 = ~pat2;
      pat3 = ~pat3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, s3_ctl.err, pat3, pat2, pat1, pat0};
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

endmodule

>>> rtl/fixed_decimal_to_seven_segment_4digit.sv
// An input transfer enters the queue, then passes stages 1 to 3 and the output register.
// Throughput: one value per cycle while the output is not stalled; the back end is a four-stage pipeline.
// A two-entry queue lets input and output stall independently.
// Reset is synchronous: it empties the queue and pipeline and sets
// decimals_mode to 2 and invert_segments to 0.
// ----------------------------------------------------------------------------
// fixed_decimal_to_seven_segment_4digit
// Fixed-point hundredths to four seven-segment digit patterns.
// ----------------------------------------------------------------------------
`include "fixed_decimal_to_seven_segment_4digit_assert.svh"

module fixed_decimal_to_seven_segment_4digit
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] value_hundredths
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] digit0_segments, [15:8] digit1_segments,
                                 // [23:16] digit2_segments, [31:24] digit3_segments,
                                 // [32] out_of_range, [39:33] zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic [1:0] decimals_mode;
  logic       invert_segments;
  cls_t       front_cls;
  cls_t       queue_cls;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;
  logic       push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimals_mode   <= MODE_RESET;
      invert_segments <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DECIMALS: decimals_mode   <= cfg_data;
        REG_INVERT:   invert_segments <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  fdss_front u_front (
    .value         (s_tdata),
    .decimals_mode (decimals_mode),
    .cls           (front_cls)
  );

  fdss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cls  (front_cls),
    .pop       (queue_pop),
    .full      (queue_full),
    .out_valid (queue_valid),
    .out_cls   (queue_cls)
  );

  fdss_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (queue_valid),
    .in_cls          (queue_cls),
    .pop             (queue_pop),
    .invert_segments (invert_segments),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  // An error result shows four dashes, plain or inverted.
  `FDSS_ASSERT_IMP(a_err_dashes, clk, rst, m_tvalid && m_tdata[32],
                   (m_tdata[31:0] == 32'h40404040) || (m_tdata[31:0] == 32'hBFBFBFBF))
  // The rightmost digit is never blank: it always carries a glyph.
  `FDSS_ASSERT_IMP(a_last_digit_lit, clk, rst, m_tvalid,
                   (m_tdata[30:24] ^ {7{invert_segments}}) != 7'h00)
  // Nothing is offered on the output right after reset.
  `FDSS_ASSERT_NEXT(a_reset_idle, clk, rst, !m_tvalid)

endmodule
